[hdl/erqt_pkg.sv]
package erqt_pkg;

  localparam int DIMENSIONS_DEF = 3;
  localparam int FRAC_BITS = 30;
  localparam int DIV_STEPS = FRAC_BITS + 1;

  localparam logic signed [32:0] THIRD_Q30 = 33'sd357913941;
  localparam logic [31:0] ONE_Q30 = 32'd1 << FRAC_BITS;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    REG_ORDER_STRENGTH = 3'd0,
    REG_ESCAPE_RADIUS  = 3'd1,
    REG_CENTER_X       = 3'd2,
    REG_CENTER_Y       = 3'd3,
    REG_CENTER_Z       = 3'd4,
    REG_AXIS_SELECT    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [61:0]        den;
    logic [2:0][61:0]   rem;
    logic [2:0][30:0]   quo;
    logic               neg_u;
    logic               neg_v;
    logic               ax_pos;
    logic               den_zero;
    logic [1:0]         axis;
  } div_t;

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

endpackage

[hdl/erqt_if.sv]
interface erqt_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface erqt_q_if;
  logic        valid;
  logic        ready;
  logic [31:0] q_xx;
  logic [31:0] q_xy;
  logic [31:0] q_xz;
  logic [31:0] q_yy;
  logic [31:0] q_yz;
  modport source (output valid, q_xx, q_xy, q_xz, q_yy, q_yz, input ready);
  modport sink (input valid, q_xx, q_xy, q_xz, q_yy, q_yz, output ready);
endinterface

interface erqt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/erqt_front.sv]
module erqt_front #(
  parameter int DIMENSIONS = erqt_pkg::DIMENSIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        px,
  input  logic [31:0]        py,
  input  logic [31:0]        pz,
  input  logic [30:0]        radius,
  input  logic [31:0]        cx,
  input  logic [31:0]        cy,
  input  logic [31:0]        cz,
  input  logic [1:0]         axis,
  output logic               out_valid,
  output erqt_pkg::div_t     out_data
);

  logic [2:0] valid;

  logic signed [32:0] dx, dy, dz, u_next, v_next;
  logic signed [32:0] u, v;
  logic [1:0] axis1, axis2, axis3;

  logic [31:0] a_full, b_full, hi;
  logic [29:0] a_s, b_s, rr_s;
  logic [29:0] a, b, rr;
  logic neg_u2, neg_v2, neg_u3, neg_v3;

  logic [59:0] aa, bb, rr2, ra, rb;
  logic [60:0] r2;
  logic [61:0] den;

  always_comb begin
    dx = $signed({px[31], px}) - $signed({cx[31], cx});
    dy = $signed({py[31], py}) - $signed({cy[31], cy});
    dz = (DIMENSIONS == 3) ? $signed({pz[31], pz}) - $signed({cz[31], cz}) : '0;
    unique case (axis)
      erqt_pkg::AXIS_X: begin
        u_next = dy;
        v_next = dz;
      end
      erqt_pkg::AXIS_Y: begin
        u_next = dz;
        v_next = dx;
      end
      default: begin
        u_next = dx;
        v_next = dy;
      end
    endcase
  end

  always_comb begin
    a_full = u[32] ? 32'(-u) : 32'(u);
    b_full = v[32] ? 32'(-v) : 32'(v);
    hi = a_full | b_full | {1'b0, radius};
    priority if (hi[31]) begin
      a_s = a_full[31:2];
      b_s = b_full[31:2];
      rr_s = {1'b0, radius[30:2]};
    end else if (hi[30]) begin
      a_s = a_full[30:1];
      b_s = b_full[30:1];
      rr_s = radius[30:1];
    end else begin
      a_s = a_full[29:0];
      b_s = b_full[29:0];
      rr_s = radius[29:0];
    end
  end

  always_comb begin
    r2 = {1'b0, aa} + {1'b0, bb};
    den = {2'b0, rr2} + {1'b0, r2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid <= {valid[1:0], in_valid};
      out_valid <= valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= u_next;
      v <= v_next;
      axis1 <= axis;
      a <= a_s;
      b <= b_s;
      rr <= rr_s;
      neg_u2 <= u[32];
      neg_v2 <= v[32];
      axis2 <= axis1;
      aa <= a * a;
      bb <= b * b;
      rr2 <= rr * rr;
      ra <= rr * a;
      rb <= rr * b;
      neg_u3 <= neg_u2;
      neg_v3 <= neg_v2;
      axis3 <= axis2;
      out_data.den <= den;
      out_data.rem[0] <= {1'b0, ra, 1'b0};
      out_data.rem[1] <= {1'b0, rb, 1'b0};
      out_data.rem[2] <= ({1'b0, rr2} >= r2) ? 62'({1'b0, rr2} - r2)
                                             : 62'(r2 - {1'b0, rr2});
      out_data.quo <= '0;
      out_data.neg_u <= neg_u3;
      out_data.neg_v <= neg_v3;
      out_data.ax_pos <= ({1'b0, rr2} >= r2);
      out_data.den_zero <= (den == '0);
      out_data.axis <= axis3;
    end
  end

endmodule

[hdl/erqt_div_cell.sv]
module erqt_div_cell #(
  parameter bit SHIFT_FIRST = 1'b1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  erqt_pkg::div_t in_data,
  output logic           out_valid,
  output erqt_pkg::div_t out_data
);

  erqt_pkg::div_t data_next;
  logic [62:0] sh;
  logic        bit_q;

  always_comb begin
    data_next = in_data;
    for (int k = 0; k < 3; k++) begin
      sh = SHIFT_FIRST ? {in_data.rem[k], 1'b0} : {1'b0, in_data.rem[k]};
      bit_q = (sh >= {1'b0, in_data.den});
      data_next.rem[k] = bit_q ? 62'(sh - {1'b0, in_data.den}) : sh[61:0];
      data_next.quo[k] = {in_data.quo[k][29:0], bit_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

[hdl/erqt_back.sv]
module erqt_back #(
  parameter int DIMENSIONS = erqt_pkg::DIMENSIONS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  erqt_pkg::div_t in_data,
  input  logic [31:0]    strength,
  output logic           out_valid,
  output logic [4:0][31:0] q
);

  logic [3:0] valid;

  logic signed [31:0] ncos, nsin, nax, n0_next, n1_next, n2_next;
  logic signed [31:0] n0, n1, n2;
  logic signed [4:0][63:0] prod;
  logic signed [4:0][32:0] t_next, t;
  logic signed [4:0][65:0] scaled;
  logic [4:0][31:0] q_next;
  logic signed [65:0] r;

  always_comb begin
    ncos = $signed({1'b0, in_data.quo[0]});
    nsin = $signed({1'b0, in_data.quo[1]});
    nax = $signed({1'b0, in_data.quo[2]});
    if (in_data.neg_u) ncos = -ncos;
    if (in_data.neg_v) nsin = -nsin;
    if (!in_data.ax_pos) nax = -nax;
    if (in_data.den_zero) begin
      ncos = '0;
      nsin = '0;
      nax = $signed(erqt_pkg::ONE_Q30);
    end
    unique case (in_data.axis)
      erqt_pkg::AXIS_X: begin
        n0_next = nax;
        n1_next = ncos;
        n2_next = nsin;
      end
      erqt_pkg::AXIS_Y: begin
        n0_next = nsin;
        n1_next = nax;
        n2_next = ncos;
      end
      default: begin
        n0_next = ncos;
        n1_next = nsin;
        n2_next = nax;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      t_next[k] = 33'(erqt_pkg::rnd30(66'($signed(prod[k]))));
      if (k == 0 || k == 3) t_next[k] = t_next[k] - erqt_pkg::THIRD_Q30;
    end
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      r = erqt_pkg::rnd30(scaled[k]);
      priority if (r > 66'sh7FFFFFFF) q_next[k] = 32'h7FFFFFFF;
      else if (r < -66'sh80000000) q_next[k] = 32'h80000000;
      else q_next[k] = r[31:0];
      if (DIMENSIONS != 3 && (k == 2 || k == 4)) q_next[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid <= {valid[2:0], in_valid};
      out_valid <= valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0 <= n0_next;
      n1 <= n1_next;
      n2 <= n2_next;
      prod[0] <= n0 * n0;
      prod[1] <= n0 * n1;
      prod[2] <= n0 * n2;
      prod[3] <= n1 * n1;
      prod[4] <= n1 * n2;
      t <= t_next;
      for (int k = 0; k < 5; k++) begin
        scaled[k] <= 66'($signed(strength) * $signed(t[k]));
      end
      q <= q_next;
    end
  end

endmodule

[hdl/escaped_radial_q_tensor_eval.sv]
// Throughput: one point per cycle; the quotient bits come from a row of
// 31 division cells, one bit per cell, with the multiplies in stages around it.
// The pipeline stalls only while a result beat waits on the output.
// Synchronous active-high reset clears the pipeline valids and loads the
// register defaults (S0 = 1.0, R = 1.0, center 0, axis z).
module escaped_radial_q_tensor_eval #(
  parameter int DIMENSIONS = erqt_pkg::DIMENSIONS_DEF
) (
  input logic             clk,
  input logic             rst,
  erqt_point_if.sink      point,
  erqt_q_if.source        q,
  erqt_cfg_if.sink        cfg
);

  logic [31:0] order_strength;
  logic [30:0] escape_radius;
  logic [31:0] center_x, center_y, center_z;
  logic [1:0]  axis_select;

  logic en;
  logic [erqt_pkg::DIV_STEPS:0] cv;
  erqt_pkg::div_t cd [erqt_pkg::DIV_STEPS + 1];
  logic [4:0][31:0] q_res;

  assign en = !q.valid || q.ready;
  assign point.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_strength <= 32'h10000000;
      escape_radius <= 31'h10000;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      axis_select <= erqt_pkg::AXIS_Z;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        erqt_pkg::REG_ORDER_STRENGTH: order_strength <= cfg.data;
        erqt_pkg::REG_ESCAPE_RADIUS:  escape_radius <= cfg.data[30:0];
        erqt_pkg::REG_CENTER_X:       center_x <= cfg.data;
        erqt_pkg::REG_CENTER_Y:       center_y <= cfg.data;
        erqt_pkg::REG_CENTER_Z:       center_z <= cfg.data;
        erqt_pkg::REG_AXIS_SELECT:    axis_select <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  erqt_front #(.DIMENSIONS(DIMENSIONS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(point.valid),
    .px(point.point_x), .py(point.point_y), .pz(point.point_z),
    .radius(escape_radius), .cx(center_x), .cy(center_y), .cz(center_z),
    .axis(axis_select), .out_valid(cv[0]), .out_data(cd[0])
  );

  for (genvar i = 0; i < erqt_pkg::DIV_STEPS; i++) begin : g_cell
    erqt_div_cell #(.SHIFT_FIRST(i != 0)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[i]), .in_data(cd[i]),
      .out_valid(cv[i+1]), .out_data(cd[i+1])
    );
  end

  erqt_back #(.DIMENSIONS(DIMENSIONS)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cv[erqt_pkg::DIV_STEPS]), .in_data(cd[erqt_pkg::DIV_STEPS]),
    .strength(order_strength), .out_valid(q.valid), .q(q_res)
  );

  assign q.q_xx = q_res[0];
  assign q.q_xy = q_res[1];
  assign q.q_xz = q_res[2];
  assign q.q_yy = q_res[3];
  assign q.q_yz = q_res[4];

  a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (q.valid && !q.ready) |-> !(point.valid && point.ready))
    else $error("point beat taken while result stalled");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (q.valid && !q.ready) |=> q.valid)
    else $error("stalled result beat lost");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !q.valid)
    else $error("result valid right after reset");

  a_planar_zero: assert property (@(posedge clk) disable iff (rst)
    (DIMENSIONS != 3 && q.valid) |-> (q.q_xz == '0 && q.q_yz == '0))
    else $error("out-of-plane term nonzero in two dimensions");

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIMS = erqt_pkg::DIMENSIONS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic [31:0] xx;
    logic [31:0] xy;
    logic [31:0] xz;
    logic [31:0] yy;
    logic [31:0] yz;
  } qten_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  erqt_point_if point();
  erqt_q_if q();
  erqt_cfg_if cfg();

  escaped_radial_q_tensor_eval #(.DIMENSIONS(DIMS)) DUT (
    .clk(clk), .rst(rst), .point(point.sink), .q(q.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [63:0] s0_q28;
  logic [63:0] radius_q16;
  logic signed [63:0] ctr_x, ctr_y, ctr_z;
  logic [1:0] axis_sel;

  point_t pending_points[$];
  qten_t expected_q[$];
  int mismatches = 0;
  int points_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit sender_hold = 0;
  logic point_taken = 1'b0;

  function automatic logic signed [63:0] sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
    logic [63:0] m;
    m = (magnitude(v) + (64'd1 << 29)) >> 30;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] ratio_q30(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = 0;
    if (rem >= den) return 64'sd1 << 30;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return $signed(quo);
  endfunction

  function automatic logic [31:0] tensor_term(logic signed [63:0] ni, logic signed [63:0] nj,
                                              bit diag);
    logic signed [63:0] t;
    logic signed [63:0] r;
    t = round_q30(ni * nj);
    if (diag) t = t - 64'sd357913941;
    r = round_q30(s0_q28 * t);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic qten_t director_q(point_t p);
    logic signed [63:0] dx, dy, dz, u, v, nc, ns, na, n0, n1, n2;
    logic [63:0] a, b, rr, m, d, r2, rr2;
    int s;
    qten_t res;
    dx = sx32(p.x) - ctr_x;
    dy = sx32(p.y) - ctr_y;
    dz = (DIMS == 3) ? sx32(p.z) - ctr_z : 64'sd0;
    if (axis_sel == erqt_pkg::AXIS_X) begin
      u = dy; v = dz;
    end else if (axis_sel == erqt_pkg::AXIS_Y) begin
      u = dz; v = dx;
    end else begin
      u = dx; v = dy;
    end
    a = magnitude(u);
    b = magnitude(v);
    rr = radius_q16;
    m = a > b ? a : b;
    if (rr > m) m = rr;
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    a = a >> s;
    b = b >> s;
    rr = rr >> s;
    r2 = a * a + b * b;
    rr2 = rr * rr;
    d = rr2 + r2;
    if (d == 0) begin
      nc = 0; ns = 0; na = 64'sd1 << 30;
    end else begin
      nc = ratio_q30(2 * rr * a, d);
      ns = ratio_q30(2 * rr * b, d);
      if (u < 0) nc = -nc;
      if (v < 0) ns = -ns;
      if (rr2 >= r2) na = ratio_q30(rr2 - r2, d);
      else na = -ratio_q30(r2 - rr2, d);
    end
    if (axis_sel == erqt_pkg::AXIS_X) begin
      n0 = na; n1 = nc; n2 = ns;
    end else if (axis_sel == erqt_pkg::AXIS_Y) begin
      n0 = ns; n1 = na; n2 = nc;
    end else begin
      n0 = nc; n1 = ns; n2 = na;
    end
    res.xx = tensor_term(n0, n0, 1);
    res.xy = tensor_term(n0, n1, 0);
    res.xz = (DIMS == 3) ? tensor_term(n0, n2, 0) : 32'd0;
    res.yy = tensor_term(n1, n1, 1);
    res.yz = (DIMS == 3) ? tensor_term(n1, n2, 0) : 32'd0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
  endtask

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    point_taken <= point.valid && point.ready;
  end

  // The sender drives new beats on the falling edge and predicts at acceptance.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (point.valid && !point_taken) begin
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      point.valid <= 1'b0;
    end else if (pending_points.size() > 0 && !sender_hold) begin
      point.valid <= 1'b1;
      {point.point_x, point.point_y, point.point_z} <= pending_points.pop_front();
      send_gap <= gap_len();
    end else begin
      point.valid <= 1'b0;
    end
  end

  int recv_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      q.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      q.ready <= 1'b0;
    end else begin
      q.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) recv_gap <= gap_len();
    end
  end

  always @(posedge clk) begin
    qten_t want;
    if (!rst) begin
      if (point.valid && point.ready) begin
        expected_q.push_back(director_q({point.point_x, point.point_y, point.point_z}));
        points_sent++;
      end
      if (cfg.valid && cfg.ready) begin
        case (erqt_pkg::cfg_reg_t'(cfg.index))
          erqt_pkg::REG_ORDER_STRENGTH: s0_q28 <= sx32(cfg.data);
          erqt_pkg::REG_ESCAPE_RADIUS:  radius_q16 <= {33'd0, cfg.data[30:0]};
          erqt_pkg::REG_CENTER_X:       ctr_x <= sx32(cfg.data);
          erqt_pkg::REG_CENTER_Y:       ctr_y <= sx32(cfg.data);
          erqt_pkg::REG_CENTER_Z:       ctr_z <= sx32(cfg.data);
          erqt_pkg::REG_AXIS_SELECT:    axis_sel <= cfg.data[1:0];
          default: ;
        endcase
      end
      if (q.valid && q.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", q.q_xx, 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (q.q_xx !== want.xx) report_mismatch("q_xx", q.q_xx, want.xx);
          if (q.q_xy !== want.xy) report_mismatch("q_xy", q.q_xy, want.xy);
          if (q.q_xz !== want.xz) report_mismatch("q_xz", q.q_xz, want.xz);
          if (q.q_yy !== want.yy) report_mismatch("q_yy", q.q_yy, want.yy);
          if (q.q_yz !== want.yz) report_mismatch("q_yz", q.q_yz, want.yz);
        end
      end
      if ((point.valid && point.ready) || (q.valid && q.ready) || (cfg.valid && cfg.ready)
          || (pending_points.size() == 0 && expected_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(erqt_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_q.size() > 0 || point.valid) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    if (pick < 7) return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
    if (pick < 8) return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
    return $urandom;
  endfunction

  task automatic random_points(int count, bit hold_mid);
    for (int i = 0; i < count; i++) begin
      pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
      if (hold_mid && i == count / 2) begin
        while (pending_points.size() > 0) @(posedge clk);
        sender_hold = 1;
        while (expected_q.size() > 0) @(posedge clk);
        sender_hold = 0;
      end
    end
  endtask

  logic [31:0] edge_vals[8] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                32'h00010000, 32'hFFFF0000, 32'h40000000};

  initial begin
    point.valid = 1'b0;
    point.point_x = '0;
    point.point_y = '0;
    point.point_z = '0;
    q.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    s0_q28 = 64'sd268435456;
    radius_q16 = 64'd65536;
    ctr_x = 0;
    ctr_y = 0;
    ctr_z = 0;
    axis_sel = erqt_pkg::AXIS_Z;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: on the axis, field extremes, and every axis selection.
    pending_points.push_back({32'h0, 32'h0, 32'h0});
    pending_points.push_back({32'h00010000, 32'h0, 32'h0});
    pending_points.push_back({32'h0, 32'hFFFF0000, 32'h12345678});
    for (int i = 0; i < 8; i++)
      pending_points.push_back({edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8]});
    drain();
    for (int ax = 0; ax < 4; ax++) begin
      write_reg(erqt_pkg::REG_AXIS_SELECT, 32'(ax));
      pending_points.push_back({32'h0, 32'h0, 32'h0});
      pending_points.push_back({32'h00008000, 32'hFFFE0000, 32'h00030000});
      pending_points.push_back({32'h80000000, 32'h7FFFFFFF, 32'h80000000});
      drain();
    end

    // Smallest nonzero radius, point on and off the axis.
    write_reg(erqt_pkg::REG_ESCAPE_RADIUS, 32'd1);
    write_reg(erqt_pkg::REG_AXIS_SELECT, 32'(erqt_pkg::AXIS_Z));
    pending_points.push_back({32'h0, 32'h0, 32'h7FFFFFFF});
    pending_points.push_back({32'h00000001, 32'h0, 32'h0});
    pending_points.push_back({32'h7FFFFFFF, 32'h80000000, 32'h0});
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_reg(erqt_pkg::REG_ORDER_STRENGTH, 32'h7FFFFFFF);
        1: write_reg(erqt_pkg::REG_ORDER_STRENGTH, 32'h80000000);
        2: write_reg(erqt_pkg::REG_ORDER_STRENGTH, $urandom);
        default: write_reg(erqt_pkg::REG_ORDER_STRENGTH,
                           32'($signed($urandom_range(0, 1 << 30)) - (1 << 29)));
      endcase
      case (phase)
        1: write_reg(erqt_pkg::REG_ESCAPE_RADIUS, 32'h7FFFFFFF);
        2: write_reg(erqt_pkg::REG_ESCAPE_RADIUS, 32'h80000000 | $urandom);
        default: write_reg(erqt_pkg::REG_ESCAPE_RADIUS, $urandom_range(1, 1 << 19));
      endcase
      write_reg(erqt_pkg::REG_CENTER_X, phase == 3 ? 32'h80000000 : rand_coord());
      write_reg(erqt_pkg::REG_CENTER_Y, phase == 3 ? 32'h7FFFFFFF : rand_coord());
      write_reg(erqt_pkg::REG_CENTER_Z, phase == 4 ? 32'h80000000 : rand_coord());
      write_reg(erqt_pkg::REG_AXIS_SELECT, 32'(phase % 4));
      random_points(200, phase == 5);
      drain();
    end

    $display("Covered %0d points over 8 register settings, all four axis codes, %0d results.",
             points_sent, results_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
